/* rtl/pcs_pkg.sv */
package pcs_pkg;

  localparam int REF_W             = 32;
  localparam int LIMIT_W           = 9;
  localparam int LEN_W             = 9;
  localparam int INDEX_W           = 8;
  localparam int MODE_W            = 3;
  localparam int CORRIDOR_DEPTH_DEF = 256;
  localparam int VISITED_DEPTH_DEF  = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APP_COR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_APP_VIS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SPLICE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [REF_W-1:0]   poly_ref;
    logic [INDEX_W-1:0] read_index;
  } pcs_in_t;

  typedef struct packed {
    logic [REF_W-1:0] read_ref;
    logic [LEN_W-1:0] corridor_length;
    logic             found;
    logic             error;
  } pcs_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRD,
    S_VRD,
    S_VCMP,
    S_PLAN,
    S_TRD,
    S_TWR,
    S_VCRD,
    S_VCWR
  } pcs_state_t;

endpackage

/* rtl/pcs_ram.sv */
module pcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/path_corridor_splice.sv */
// clear, append and read items: one accepted per cycle, result strobe one cycle after accept
// splice: busy for at most cc*(1+2*vc) + 2*(run+tail) + 1 cycles, set by the search over
// both single-read-port stores and the copy back through the corridor store
// result strobe lasts one cycle, in the cycle after busy falls; the receiver cannot stall it
// synchronous active-low reset clears both counts, the output strobe and sets the limit to 256
// store contents are not cleared; entries beyond the counts are never read
module path_corridor_splice #(
  parameter int CORRIDOR_DEPTH = pcs_pkg::CORRIDOR_DEPTH_DEF,
  parameter int VISITED_DEPTH  = pcs_pkg::VISITED_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  pcs_pkg::pcs_in_t             in_item,
  output logic                         out_valid,
  output pcs_pkg::pcs_out_t            out_item,
  input  logic                         cfg_we,
  input  logic [pcs_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import pcs_pkg::*;

  localparam int CD  = CORRIDOR_DEPTH;
  localparam int VD  = VISITED_DEPTH;
  localparam int CW  = $clog2(CD + 1);
  localparam int AW  = $clog2(CD);
  localparam int VCW = $clog2(VD + 1);
  localparam int VAW = (VD > 1) ? $clog2(VD) : 1;
  localparam int PW0 = (CW > VCW) ? CW : VCW;
  localparam int PW  = ((PW0 > LIMIT_W) ? PW0 : LIMIT_W) + 1;
  localparam int IW  = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

  pcs_state_t state_r, state_nxt;

  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      cc_r, cc_nxt;
  logic [VCW-1:0]     vc_r, vc_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [VAW-1:0]     j_r, j_nxt;
  logic [CW-1:0]      run_r, run_nxt;
  logic [CW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      start_r, start_nxt;
  logic               desc_r, desc_nxt;
  logic [CW-1:0]      n_r, n_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               rd_sel_r, rd_sel_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               found_r, found_nxt;
  logic               err_r, err_nxt;

  logic               c_we, c_re, v_we, v_re;
  logic [AW-1:0]      c_waddr, c_raddr;
  logic [VAW-1:0]     v_waddr, v_raddr;
  logic [REF_W-1:0]   c_wdata, c_rdata, v_wdata, v_rdata;

  logic               accept;
  logic [PW-1:0]      lim_w, run_w, start_w, tail_w, run_c, tail_c;
  logic [CW-1:0]      k_tail;
  logic [IW-1:0]      idx_w;
  logic [CW-1:0]      new_len;

  pcs_ram #(.WIDTH(REF_W), .DEPTH(CD), .AW(AW)) u_cor_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  pcs_ram #(.WIDTH(REF_W), .DEPTH(VD), .AW(VAW)) u_vis_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // splice plan, from the matched positions
  assign lim_w   = (PW'(limit_r) > PW'(CD)) ? PW'(CD) : PW'(limit_r);
  assign run_w   = PW'(vc_r) - PW'(j_r);
  assign start_w = PW'(i_r) + PW'(1);
  assign tail_w  = PW'(cc_r) - start_w;
  assign run_c   = (run_w > lim_w) ? lim_w : run_w;
  assign tail_c  = ((run_c + tail_w) > lim_w) ? (lim_w - run_c) : tail_w;

  assign k_tail  = desc_r ? (tail_r - n_r - CW'(1)) : n_r;
  assign idx_w   = IW'(in_item.read_index);
  assign new_len = run_r + tail_r;

  always_comb begin
    state_nxt     = state_r;
    cc_nxt        = cc_r;
    vc_nxt        = vc_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    run_nxt       = run_r;
    tail_nxt      = tail_r;
    start_nxt     = start_r;
    desc_nxt      = desc_r;
    n_nxt         = n_r;
    out_valid_nxt = 1'b0;
    rd_sel_nxt    = 1'b0;
    len_nxt       = len_r;
    found_nxt     = 1'b0;
    err_nxt       = 1'b0;
    c_we          = 1'b0;
    c_waddr       = AW'(cc_r);
    c_wdata       = in_item.poly_ref;
    c_re          = 1'b0;
    c_raddr       = AW'(in_item.read_index);
    v_we          = 1'b0;
    v_waddr       = VAW'(vc_r);
    v_wdata       = in_item.poly_ref;
    v_re          = 1'b0;
    v_raddr       = j_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          len_nxt       = LEN_W'(cc_r);
          unique case (in_item.mode)
            MODE_CLEAR: begin
              cc_nxt  = '0;
              vc_nxt  = '0;
              len_nxt = '0;
            end
            MODE_APP_COR: begin
              if (cc_r < CW'(CD)) begin
                c_we    = 1'b1;
                cc_nxt  = cc_r + CW'(1);
                len_nxt = LEN_W'(cc_r + CW'(1));
              end else begin
                err_nxt = 1'b1;
              end
            end
            MODE_APP_VIS: begin
              if (vc_r < VCW'(VD)) begin
                v_we   = 1'b1;
                vc_nxt = vc_r + VCW'(1);
              end else begin
                err_nxt = 1'b1;
              end
            end
            MODE_SPLICE: begin
              if ((cc_r == '0) || (vc_r == '0)) begin
                vc_nxt = '0;
              end else begin
                out_valid_nxt = 1'b0;
                i_nxt         = AW'(cc_r - CW'(1));
                state_nxt     = S_CRD;
              end
            end
            MODE_READ: begin
              if ((idx_w < IW'(cc_r)) && (idx_w < IW'(CD))) begin
                c_re       = 1'b1;
                rd_sel_nxt = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CRD: begin
        c_re      = 1'b1;
        c_raddr   = i_r;
        j_nxt     = '0;
        state_nxt = S_VRD;
      end
      S_VRD: begin
        v_re      = 1'b1;
        state_nxt = S_VCMP;
      end
      S_VCMP: begin
        if (v_rdata == c_rdata) begin
          state_nxt = S_PLAN;
        end else if ((PW'(j_r) + PW'(1)) != PW'(vc_r)) begin
          j_nxt     = j_r + VAW'(1);
          state_nxt = S_VRD;
        end else if (i_r != '0) begin
          i_nxt     = i_r - AW'(1);
          state_nxt = S_CRD;
        end else begin
          vc_nxt        = '0;
          out_valid_nxt = 1'b1;
          len_nxt       = LEN_W'(cc_r);
          state_nxt     = S_IDLE;
        end
      end
      S_PLAN: begin
        run_nxt   = CW'(run_c);
        tail_nxt  = CW'(tail_c);
        start_nxt = CW'(start_w);
        desc_nxt  = (run_c > start_w);
        n_nxt     = '0;
        if (tail_c != '0) begin
          state_nxt = S_TRD;
        end else if (run_c != '0) begin
          state_nxt = S_VCRD;
        end else begin
          cc_nxt        = '0;
          vc_nxt        = '0;
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          len_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_TRD: begin
        c_re      = 1'b1;
        c_raddr   = AW'(start_r + k_tail);
        state_nxt = S_TWR;
      end
      S_TWR: begin
        c_we    = 1'b1;
        c_waddr = AW'(run_r + k_tail);
        c_wdata = c_rdata;
        if ((n_r + CW'(1)) == tail_r) begin
          n_nxt = '0;
          if (run_r != '0) begin
            state_nxt = S_VCRD;
          end else begin
            cc_nxt        = new_len;
            vc_nxt        = '0;
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b1;
            len_nxt       = LEN_W'(new_len);
            state_nxt     = S_IDLE;
          end
        end else begin
          n_nxt     = n_r + CW'(1);
          state_nxt = S_TRD;
        end
      end
      S_VCRD: begin
        v_re      = 1'b1;
        v_raddr   = VAW'(PW'(vc_r) - PW'(n_r) - PW'(1));
        state_nxt = S_VCWR;
      end
      S_VCWR: begin
        c_we    = 1'b1;
        c_waddr = AW'(n_r);
        c_wdata = v_rdata;
        if ((n_r + CW'(1)) == run_r) begin
          cc_nxt        = new_len;
          vc_nxt        = '0;
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          len_nxt       = LEN_W'(new_len);
          state_nxt     = S_IDLE;
        end else begin
          n_nxt     = n_r + CW'(1);
          state_nxt = S_VCRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cc_r        <= '0;
      vc_r        <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cc_r        <= cc_nxt;
      vc_r        <= vc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    run_r    <= run_nxt;
    tail_r   <= tail_nxt;
    start_r  <= start_nxt;
    desc_r   <= desc_nxt;
    n_r      <= n_nxt;
    rd_sel_r <= rd_sel_nxt;
    len_r    <= len_nxt;
    found_r  <= found_nxt;
    err_r    <= err_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_item.read_ref        = rd_sel_r ? c_rdata : '0;
  assign out_item.corridor_length = len_r;
  assign out_item.found           = found_r;
  assign out_item.error           = err_r;

`ifndef SYNTH
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe during splice");

  a_splice_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.mode == MODE_SPLICE) && (cc_r != '0) && (vc_r != '0)) |=> busy)
    else $error("splice did not start search");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r <= CW'(CD))
    else $error("corridor count beyond depth");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.mode == MODE_APP_COR) && (cc_r < CW'(CD)))
      |=> (cc_r == $past(cc_r) + CW'(1)))
    else $error("corridor append lost");

  a_found_empties_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |-> (vc_r == '0))
    else $error("visited list kept after splice");
`endif

endmodule

/* dv/tb_path_corridor_splice.sv */
module tb_path_corridor_splice;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  localparam int ITEM_GOAL      = 1400;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASES         = 8;

  class corridor_shadow;
    logic [REF_W-1:0]   corridor [CORRIDOR_DEPTH_DEF];
    logic [REF_W-1:0]   visited [VISITED_DEPTH_DEF];
    int unsigned        corridor_cnt;
    int unsigned        visited_cnt;
    logic [LIMIT_W-1:0] length_cap;
    pcs_out_t           predicted_reports [$];
    int unsigned        mismatches;

    function new();
      corridor_cnt = 0;
      visited_cnt  = 0;
      length_cap   = LIMIT_RESET;
      mismatches   = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      length_cap = value;
    endfunction

    function int unsigned pending();
      return predicted_reports.size();
    endfunction

    function bit splice_visited();
      logic [REF_W-1:0] spliced [CORRIDOR_DEPTH_DEF];
      int unsigned      cap, run, tail, tail_at, hit_c, hit_v, i, j, k;
      bit               hit;
      cap   = (length_cap > CORRIDOR_DEPTH_DEF) ? CORRIDOR_DEPTH_DEF : length_cap;
      hit   = 1'b0;
      hit_c = 0;
      hit_v = 0;
      for (i = corridor_cnt; i > 0 && !hit; i--) begin
        for (j = 0; j < visited_cnt && !hit; j++) begin
          if (corridor[i-1] == visited[j]) begin
            hit   = 1'b1;
            hit_c = i - 1;
            hit_v = j;
          end
        end
      end
      if (hit) begin
        run     = visited_cnt - hit_v;
        tail_at = hit_c + 1;
        tail    = corridor_cnt - tail_at;
        if (run > cap) run = cap;
        if (run + tail > cap) tail = cap - run;
        for (k = 0; k < run; k++) spliced[k] = visited[visited_cnt - 1 - k];
        for (k = 0; k < tail; k++) spliced[run + k] = corridor[tail_at + k];
        for (k = 0; k < run + tail; k++) corridor[k] = spliced[k];
        corridor_cnt = run + tail;
      end
      visited_cnt = 0;
      return hit;
    endfunction

    function void apply_op(pcs_in_t it);
      pcs_out_t rpt;
      rpt = '0;
      case (it.mode)
        MODE_CLEAR: begin
          corridor_cnt = 0;
          visited_cnt  = 0;
        end
        MODE_APP_COR: begin
          if (corridor_cnt < CORRIDOR_DEPTH_DEF) begin
            corridor[corridor_cnt] = it.poly_ref;
            corridor_cnt++;
          end else begin
            rpt.error = 1'b1;
          end
        end
        MODE_APP_VIS: begin
          if (visited_cnt < VISITED_DEPTH_DEF) begin
            visited[visited_cnt] = it.poly_ref;
            visited_cnt++;
          end else begin
            rpt.error = 1'b1;
          end
        end
        MODE_SPLICE: begin
          rpt.found = splice_visited();
        end
        MODE_READ: begin
          if (it.read_index < corridor_cnt) rpt.read_ref = corridor[it.read_index];
          else rpt.error = 1'b1;
        end
        default: begin
        end
      endcase
      rpt.corridor_length = LEN_W'(corridor_cnt);
      predicted_reports.push_back(rpt);
    endfunction

    function void compare_report(pcs_out_t got);
      pcs_out_t want;
      if (predicted_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with no item outstanding: ref=%h len=%0d found=%b err=%b",
                 $time, got.read_ref, got.corridor_length, got.found, got.error);
        return;
      end
      want = predicted_reports.pop_front();
      if (got.read_ref !== want.read_ref || got.corridor_length !== want.corridor_length ||
          got.found !== want.found || got.error !== want.error) begin
        mismatches++;
        $display("%0t: expected ref=%h len=%0d found=%b err=%b", $time,
                 want.read_ref, want.corridor_length, want.found, want.error);
        $display("%0t: actual   ref=%h len=%0d found=%b err=%b", $time,
                 got.read_ref, got.corridor_length, got.found, got.error);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  pcs_in_t            in_item   = '0;
  logic               out_valid;
  pcs_out_t           out_item;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  corridor_shadow shadow;
  int unsigned    items_sent = 0;
  int unsigned    idle_cycles = 0;

  path_corridor_splice dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // item and report capture, plus stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) shadow.compare_report(out_item);
      if (start && !busy) shadow.apply_op(in_item);
      if (out_valid || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [REF_W-1:0] route_ref(logic [REF_W-1:0] base, int unsigned span);
    if ($urandom_range(0, 99) < 85) return base + $urandom_range(0, span);
    return $urandom();
  endfunction

  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [REF_W-1:0] poly,
                         input logic [INDEX_W-1:0] idx, input bit burst);
    pcs_in_t     it;
    int unsigned gap;
    it.mode       = mode;
    it.poly_ref   = poly;
    it.read_index = idx;
    gap = pick_gap(burst);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (mode <= MODE_READ) items_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_reports();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0 || busy);
  endtask

  task automatic set_length_limit(input logic [LIMIT_W-1:0] value);
    wait_for_reports();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_limit(value);
  endtask

  task automatic run_directed();
    int unsigned k;
    send_op(MODE_READ, '0, '0, 1'b0);
    send_op(MODE_SPLICE, '0, '0, 1'b0);
    for (k = MODE_READ + 1; k < 2**MODE_W; k++) send_op(MODE_W'(k), '1, '1, 1'b0);
    send_op(MODE_APP_COR, 32'h0000_0000, '0, 1'b0);
    send_op(MODE_APP_COR, 32'hFFFF_FFFF, '1, 1'b0);
    send_op(MODE_APP_COR, 32'h1234_5678, '0, 1'b0);
    send_op(MODE_APP_COR, 32'hA5A5_A5A5, '0, 1'b0);
    send_op(MODE_APP_VIS, 32'hDEAD_BEEF, '0, 1'b0);
    send_op(MODE_APP_VIS, 32'h1234_5678, '0, 1'b0);
    send_op(MODE_APP_VIS, 32'hCAFE_F00D, '0, 1'b0);
    send_op(MODE_SPLICE, '0, '0, 1'b0);
    send_op(MODE_READ, '0, 8'd0, 1'b0);
    send_op(MODE_READ, '0, 8'd2, 1'b0);
    send_op(MODE_READ, '0, 8'd3, 1'b0);
    send_op(MODE_READ, '0, '1, 1'b0);
    // visited list with nothing in common
    send_op(MODE_APP_VIS, 32'h5555_5555, '0, 1'b0);
    send_op(MODE_SPLICE, '0, '0, 1'b0);
    send_op(MODE_READ, '0, 8'd1, 1'b0);
    send_op(MODE_CLEAR, '1, '1, 1'b0);
    send_op(MODE_READ, '0, 8'd0, 1'b0);
  endtask

  // both stores past full, then splice and read back
  task automatic fill_stores();
    int unsigned      k;
    logic [REF_W-1:0] base;
    base = $urandom();
    send_op(MODE_CLEAR, $urandom(), INDEX_W'($urandom()), 1'b0);
    for (k = 0; k < CORRIDOR_DEPTH_DEF + 1; k++)
      send_op(MODE_APP_COR, base + k, INDEX_W'($urandom()), 1'b1);
    for (k = 0; k < VISITED_DEPTH_DEF + 1; k++)
      send_op(MODE_APP_VIS, base + $urandom_range(0, 2 * CORRIDOR_DEPTH_DEF),
              INDEX_W'($urandom()), 1'b0);
    send_op(MODE_SPLICE, $urandom(), INDEX_W'($urandom()), 1'b0);
    for (k = 0; k < 4; k++) send_op(MODE_READ, $urandom(), INDEX_W'($urandom()), 1'b0);
  endtask

  task automatic run_route();
    int unsigned       n_cor, n_vis, n_rd, k, span;
    logic [REF_W-1:0]  base;
    logic [INDEX_W-1:0] idx;
    bit                burst;
    burst = ($urandom_range(0, 3) == 0);
    base  = $urandom();
    span  = $urandom_range(1, 48);
    if ($urandom_range(0, 1) == 0) send_op(MODE_CLEAR, $urandom(), INDEX_W'($urandom()), burst);
    n_cor = ($urandom_range(0, 24) == 0) ? $urandom_range(180, 260) : $urandom_range(0, 24);
    for (k = 0; k < n_cor; k++)
      send_op(MODE_APP_COR, route_ref(base, span), INDEX_W'($urandom()), burst);
    n_vis = $urandom_range(0, VISITED_DEPTH_DEF + 1);
    for (k = 0; k < n_vis; k++)
      send_op(MODE_APP_VIS, route_ref(base, span), INDEX_W'($urandom()), burst);
    if ($urandom_range(0, 4) == 0)
      send_op(MODE_W'($urandom_range(0, 2**MODE_W - 1)), $urandom(), INDEX_W'($urandom()),
              burst);
    if ($urandom_range(0, 9) != 0) send_op(MODE_SPLICE, $urandom(), INDEX_W'($urandom()), burst);
    n_rd = $urandom_range(0, 6);
    for (k = 0; k < n_rd; k++) begin
      idx = ($urandom_range(0, 3) != 0) ? INDEX_W'($urandom_range(0, 20)) : INDEX_W'($urandom());
      send_op(MODE_READ, $urandom(), idx, burst);
    end
    if ($urandom_range(0, 9) == 0) wait_for_reports();
  endtask

  initial begin
    int unsigned        p, r;
    logic [LIMIT_W-1:0] plan [PHASES];
    shadow = new();
    plan = '{LIMIT_RESET, 9'd1, 9'd0, 9'd511, 9'd5, 9'd257,
             LIMIT_W'($urandom_range(2, 255)), LIMIT_RESET};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    fill_stores();
    for (p = 0; p < PHASES; p++) begin
      if (p != 0) set_length_limit(plan[p]);
      if (plan[p] == '1) fill_stores();
      for (r = 0; r < 4 || items_sent < (p + 1) * ITEM_GOAL / PHASES; r++) run_route();
    end
    wait_for_reports();
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/path_corridor_splice.sv
dv/tb_path_corridor_splice.sv
